@@ rtl/core/qte_pkg.sv @@
package qte_pkg;

    localparam int QUAT_W        = 16;
    localparam int TERM_W        = 32;
    localparam int CORD_W        = 36;
    localparam int ANG_W         = 28;
    localparam int SQRT_CELLS    = 31;
    localparam int ATAN_ENTRIES  = 24;
    localparam int DEF_ANGLE_ITERATIONS = 16;

    localparam logic signed [ANG_W-1:0] HALF_TURN   = 28'sd11796480;
    localparam logic signed [ANG_W-1:0] ROLL_LIMIT  = 28'sd23040;
    localparam logic signed [ANG_W-1:0] PITCH_LIMIT = 28'sd11520;

    typedef struct packed {
        logic signed [TERM_W-1:0] r21;
        logic signed [TERM_W-1:0] r22;
        logic signed [TERM_W-1:0] r00;
        logic signed [TERM_W-1:0] r10;
        logic signed [TERM_W-1:0] r20n;
    } terms_t;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
        logic                     zero;
    } lane_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        logic signed [ANG_W-1:0] v;
        begin
            unique case (i)
                0:  v = 28'sd2949120;
                1:  v = 28'sd1740967;
                2:  v = 28'sd919879;
                3:  v = 28'sd466945;
                4:  v = 28'sd234379;
                5:  v = 28'sd117304;
                6:  v = 28'sd58666;
                7:  v = 28'sd29335;
                8:  v = 28'sd14668;
                9:  v = 28'sd7334;
                10: v = 28'sd3667;
                11: v = 28'sd1833;
                12: v = 28'sd917;
                13: v = 28'sd458;
                14: v = 28'sd229;
                15: v = 28'sd115;
                16: v = 28'sd57;
                17: v = 28'sd29;
                18: v = 28'sd14;
                19: v = 28'sd7;
                20: v = 28'sd4;
                21: v = 28'sd2;
                22: v = 28'sd1;
                default: v = 28'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ rtl/core/quaternion_to_euler_zyx_unit.sv @@
// Quaternion to Z-Y-X Euler angles. Takes one signed Q1.14 unit quaternion per
// cycle and returns roll, pitch and yaw in 1/128 degree, saturated to +-180,
// +-90 and +-180 degrees. The unit is a fixed pipeline: one request enters
// every cycle unless the pipeline is frozen, and its result passes through
// 4 product/term stages, 31 square-root cells that settle one root bit each,
// one setup stage, one CORDIC cell per iteration, and the output register.
// Throughput is one request per cycle; out_stall against a waiting result
// freezes the whole pipeline, and in_stall then follows it.
module quaternion_to_euler_zyx_unit
    import qte_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = DEF_ANGLE_ITERATIONS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [QUAT_W-1:0] quat_w,
    input  logic signed [QUAT_W-1:0] quat_x,
    input  logic signed [QUAT_W-1:0] quat_y,
    input  logic signed [QUAT_W-1:0] quat_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [15:0]       roll_angle,
    output logic signed [14:0]       pitch_angle,
    output logic signed [15:0]       yaw_angle
);

    localparam int DEPTH = 4 + SQRT_CELLS + 1 + ANGLE_ITERATIONS + 1;

    // pipeline moves as a whole unless the output holds an untaken result
    logic en;
    logic [DEPTH-1:0] vld_reg, vld_next;

    assign en       = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !en;
    assign out_valid = vld_reg[DEPTH-1];

    always_comb
    begin
        vld_next = {vld_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: component products, exact in Q.28
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, wz_reg, xz_reg, wy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= 32'(quat_w) * 32'(quat_x);
            yz_reg <= 32'(quat_y) * 32'(quat_z);
            xx_reg <= 32'(quat_x) * 32'(quat_x);
            yy_reg <= 32'(quat_y) * 32'(quat_y);
            zz_reg <= 32'(quat_z) * 32'(quat_z);
            xy_reg <= 32'(quat_x) * 32'(quat_y);
            wz_reg <= 32'(quat_w) * 32'(quat_z);
            xz_reg <= 32'(quat_x) * 32'(quat_z);
            wy_reg <= 32'(quat_w) * 32'(quat_y);
        end
    end

    // stage 2: rotation terms, cut to Q.24 with floor
    localparam logic signed [CORD_W-1:0] ONE = 36'sd268435456;
    logic signed [CORD_W-1:0] t21, t22, t00, t10, t20n;
    terms_t terms_reg, terms_next;

    always_comb
    begin
        t21  = (CORD_W'(yz_reg) + CORD_W'(wx_reg)) <<< 1;
        t22  = ONE - ((CORD_W'(xx_reg) + CORD_W'(yy_reg)) <<< 1);
        t00  = ONE - ((CORD_W'(yy_reg) + CORD_W'(zz_reg)) <<< 1);
        t10  = (CORD_W'(xy_reg) + CORD_W'(wz_reg)) <<< 1;
        t20n = (CORD_W'(wy_reg) - CORD_W'(xz_reg)) <<< 1;
        terms_next.r21  = TERM_W'(t21 >>> 4);
        terms_next.r22  = TERM_W'(t22 >>> 4);
        terms_next.r00  = TERM_W'(t00 >>> 4);
        terms_next.r10  = TERM_W'(t10 >>> 4);
        terms_next.r20n = TERM_W'(t20n >>> 4);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            terms_reg <= terms_next;
        end
    end

    // stage 3: squares of |R00| and |R10|
    logic [TERM_W-1:0] a0, a1;
    logic [63:0] sq0_reg, sq1_reg;
    terms_t terms2_reg;

    assign a0 = terms_reg.r00[TERM_W-1] ? TERM_W'(-terms_reg.r00) : TERM_W'(terms_reg.r00);
    assign a1 = terms_reg.r10[TERM_W-1] ? TERM_W'(-terms_reg.r10) : TERM_W'(terms_reg.r10);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq0_reg    <= 64'(a0) * 64'(a0);
            sq1_reg    <= 64'(a1) * 64'(a1);
            terms2_reg <= terms_reg;
        end
    end

    // stage 4: sum of squares
    logic [63:0] sum_reg;
    terms_t terms3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg    <= sq0_reg + sq1_reg;
            terms3_reg <= terms2_reg;
        end
    end

    // square-root cells, one root bit each
    logic [63:0] sq_n    [0:SQRT_CELLS];
    logic [63:0] sq_root [0:SQRT_CELLS];
    terms_t      sq_terms[0:SQRT_CELLS];

    assign sq_n[0]     = sum_reg;
    assign sq_root[0]  = '0;
    assign sq_terms[0] = terms3_reg;

    for (genvar k = 0; k < SQRT_CELLS; k++)
    begin : g_sqrt
        qte_sqrt_cell #(.STEP(k)) u_cell (
            .clk      (clk),
            .en       (en),
            .n_in     (sq_n[k]),
            .root_in  (sq_root[k]),
            .terms_in (sq_terms[k]),
            .n_out    (sq_n[k+1]),
            .root_out (sq_root[k+1]),
            .terms_out(sq_terms[k+1])
        );
    end

    // setup: lanes are roll, pitch, yaw; left half plane turned by 180 degrees
    function automatic lane_t lane_setup(input logic signed [CORD_W-1:0] num,
                                         input logic signed [CORD_W-1:0] den);
        lane_t l;
        begin
            l.zero = (num == '0) && (den == '0);
            if (den < 0)
            begin
                l.x = -den;
                l.y = -num;
                l.z = (num >= 0) ? HALF_TURN : -HALF_TURN;
            end
            else
            begin
                l.x = den;
                l.y = num;
                l.z = '0;
            end
            return l;
        end
    endfunction

    terms_t      tq;
    logic signed [CORD_W-1:0] cp;
    lane_t [2:0] setup_reg, setup_next;

    assign tq = sq_terms[SQRT_CELLS];
    assign cp = $signed({(CORD_W - 31)'(0), sq_root[SQRT_CELLS][30:0]});

    always_comb
    begin
        setup_next[0] = lane_setup(CORD_W'(tq.r21), CORD_W'(tq.r22));
        setup_next[1] = lane_setup(CORD_W'(tq.r20n), cp);
        setup_next[2] = lane_setup(CORD_W'(tq.r10), CORD_W'(tq.r00));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            setup_reg <= setup_next;
        end
    end

    // vectoring cordic cells
    lane_t [2:0] cd [0:ANGLE_ITERATIONS];
    assign cd[0] = setup_reg;

    for (genvar i = 0; i < ANGLE_ITERATIONS; i++)
    begin : g_cordic
        qte_cordic_cell #(.STEP(i)) u_cell (
            .clk     (clk),
            .en      (en),
            .lane_in (cd[i]),
            .lane_out(cd[i+1])
        );
    end

    // rounding to 1/128 degree and saturation
    function automatic logic signed [ANG_W-1:0] finish(input lane_t l,
                                                       input logic signed [ANG_W-1:0] lim);
        logic signed [ANG_W-1:0] r;
        begin
            r = (l.z + 28'sd256) >>> 9;
            if (l.zero)
                r = '0;
            else if (r > lim)
                r = lim;
            else if (r < -lim)
                r = -lim;
            return r;
        end
    endfunction

    logic signed [ANG_W-1:0] roll_r, pitch_r, yaw_r;
    logic signed [15:0] roll_reg, yaw_reg;
    logic signed [14:0] pitch_reg;

    assign roll_r  = finish(cd[ANGLE_ITERATIONS][0], ROLL_LIMIT);
    assign pitch_r = finish(cd[ANGLE_ITERATIONS][1], PITCH_LIMIT);
    assign yaw_r   = finish(cd[ANGLE_ITERATIONS][2], ROLL_LIMIT);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= roll_r[15:0];
            pitch_reg <= pitch_r[14:0];
            yaw_reg   <= yaw_r[15:0];
        end
    end

    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;

endmodule

@@ rtl/core/qte_sqrt_cell.sv @@
module qte_sqrt_cell
    import qte_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] n_in,
    input  logic [63:0] root_in,
    input  terms_t      terms_in,
    output logic [63:0] n_out,
    output logic [63:0] root_out,
    output terms_t      terms_out
);

    localparam logic [63:0] BIT = 64'(1) << (60 - 2 * STEP);

    logic [63:0] n_reg, n_next, root_reg, root_next, trial;
    terms_t      terms_reg;

    always_comb
    begin
        trial = root_in + BIT;
        if (n_in >= trial)
        begin
            n_next    = n_in - trial;
            root_next = (root_in >> 1) + BIT;
        end
        else
        begin
            n_next    = n_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg     <= n_next;
            root_reg  <= root_next;
            terms_reg <= terms_in;
        end
    end

    assign n_out     = n_reg;
    assign root_out  = root_reg;
    assign terms_out = terms_reg;

endmodule

@@ rtl/core/qte_cordic_cell.sv @@
module qte_cordic_cell
    import qte_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic        clk,
    input  logic        en,
    input  lane_t [2:0] lane_in,
    output lane_t [2:0] lane_out
);

    localparam logic signed [ANG_W-1:0] ATAN = atan_step(STEP);

    lane_t [2:0] lane_reg, lane_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lane_next[k].zero = lane_in[k].zero;
            if (lane_in[k].y > 0)
            begin
                lane_next[k].x = lane_in[k].x + (lane_in[k].y >>> STEP);
                lane_next[k].y = lane_in[k].y - (lane_in[k].x >>> STEP);
                lane_next[k].z = lane_in[k].z + ATAN;
            end
            else
            begin
                lane_next[k].x = lane_in[k].x - (lane_in[k].y >>> STEP);
                lane_next[k].y = lane_in[k].y + (lane_in[k].x >>> STEP);
                lane_next[k].z = lane_in[k].z - ATAN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

@@ rtl/core/qte_checker.sv @@
module qte_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] roll_angle,
    input logic signed [14:0] pitch_angle,
    input logic signed [15:0] yaw_angle
);

    // held result keeps its angles
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pitch_angle) && $stable(roll_angle)
                                 && $stable(yaw_angle))
        else $error("stalled result changed");

    a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pitch_angle <= 15'sd11520 && pitch_angle >= -15'sd11520)
        else $error("pitch out of range");

    a_roll_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> roll_angle <= 16'sd23040 && roll_angle >= -16'sd23040
                   && yaw_angle <= 16'sd23040 && yaw_angle >= -16'sd23040)
        else $error("roll or yaw out of range");

    // input is held off exactly while a result waits
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall mismatch");

    a_reset: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result during reset");

endmodule

bind quaternion_to_euler_zyx_unit qte_checker u_qte_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .roll_angle (roll_angle),
    .pitch_angle(pitch_angle),
    .yaw_angle  (yaw_angle)
);
